>>> hdl/seq_reorder_buffer_core_defines.svh
// Assertion macros for the reorder buffer checker
`ifndef SEQ_REORDER_BUFFER_CORE_DEFINES_SVH
`define SEQ_REORDER_BUFFER_CORE_DEFINES_SVH
// implication checked every clock, off during reset
`define SRB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define SRB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hdl/srb_pkg.sv
// Shared types and constants of the reorder buffer
package srb_pkg;
  localparam int unsigned SeqW = 16;
  localparam logic [8:0] WaitMax = 9'd511;
  localparam logic [5:0] RunMax = 6'd32;

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_RETX    = 2'd1,
    KIND_LOST    = 2'd2,
    KIND_DROP    = 2'd3
  } kind_e;

  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_HOLD = 1'b0,
    REG_RUN  = 1'b1
  } reg_e;
endpackage

>>> hdl/seq_reorder_buffer_core.sv
// Reorder buffer: one slot of the store is visited per cycle by a shared compare unit.
// Every search (arrival lookup, each drain step, nearest-number scan on tick) walks all DEPTH
// slots, then decides; a first packet is delivered in the cycle after acceptance, an in-order
// one after a drain search. A stored packet holds in_stall_o high over an arrival and a drain
// search; results wait in S_EMIT while out_stall_i is high, retransmits are formed in S_REQ.
// Async active-low reset clears control state and valid bits; config resets to hold 5, run 8.
module seq_reorder_buffer_core import srb_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [15:0] seq_i,
  input  logic [15:0] handle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] out_seq_o,
  output logic [15:0] out_handle_o,
  output logic [15:0] lost_count_o,
  output logic        last_o
);
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_ASCAN, S_ADEC, S_DSCAN, S_DDEC, S_TSCAN, S_TDEC, S_REQ, S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    RET_IDLE, RET_DRAIN, RET_REQ
  } ret_e;

  state_e state_q;
  ret_e ret_q;
  logic [7:0] hold_q;
  logic [5:0] run_q;
  logic started_q, wait_act_q;
  logic [8:0] wait_q;
  logic [15:0] ld_q;
  logic [DEPTH-1:0] vld_q;
  logic [15:0] eseq_q [DEPTH];
  logic [15:0] ehdl_q [DEPTH];
  logic [15:0] seq_q, hdl_q;
  logic [IdxW-1:0] idx_q, hit_q, free_q;
  logic hit_v_q, free_v_q;
  logic pend_q;
  logic [15:0] best_q, bseq_q;
  logic [5:0] ask_q, reqi_q;
  logic [1:0] okind_q;
  logic [15:0] oseq_q, ohdl_q, olost_q;
  logic olast_q;
  logic [15:0] key, fwd, nxt, d_cur;
  logic scan_end, hit_now;
  logic [5:0] run_cap;

  assign nxt = ld_q + 16'd1;
  assign key = (state_q == S_ASCAN) ? seq_q : nxt;
  assign hit_now = vld_q[idx_q] && (eseq_q[idx_q] == key);
  assign d_cur = eseq_q[idx_q] - nxt;
  assign scan_end = (idx_q == IdxW'(DEPTH - 1));
  assign fwd = seq_i - ld_q;
  assign run_cap = (run_q > RunMax) ? RunMax : run_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);
  assign kind_o = okind_q;
  assign out_seq_o = oseq_q;
  assign out_handle_o = ohdl_q;
  assign lost_count_o = olost_q;
  assign last_o = olast_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && command_i == CMD_ARRIVE) begin
      seq_q <= seq_i;
      hdl_q <= handle_i;
    end
    if (state_q == S_ADEC && !hit_v_q && free_v_q && seq_q - ld_q != 16'd1) begin
      eseq_q[free_q] <= seq_q;
      ehdl_q[free_q] <= hdl_q;
    end else if (state_q == S_ADEC && hit_v_q) begin
      ehdl_q[hit_q] <= hdl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q <= RET_IDLE;
      hold_q <= 8'd5;
      run_q <= 6'd8;
      started_q <= 1'b0;
      wait_act_q <= 1'b0;
      wait_q <= '0;
      ld_q <= '0;
      vld_q <= '0;
      idx_q <= '0;
      hit_q <= '0;
      free_q <= '0;
      hit_v_q <= 1'b0;
      free_v_q <= 1'b0;
      pend_q <= 1'b0;
      best_q <= '0;
      bseq_q <= '0;
      ask_q <= '0;
      reqi_q <= '0;
      okind_q <= KIND_DELIVER;
      oseq_q <= '0;
      ohdl_q <= '0;
      olost_q <= '0;
      olast_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_HOLD: hold_q <= cfg_wdata_i;
          REG_RUN:  run_q <= cfg_wdata_i[5:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          hit_v_q <= 1'b0;
          free_v_q <= 1'b0;
          if (in_valid_i) begin
            if (command_i == CMD_ARRIVE) begin
              if (!started_q) begin
                started_q <= 1'b1;
                ld_q <= seq_i;
                okind_q <= KIND_DELIVER;
                oseq_q <= seq_i;
                ohdl_q <= handle_i;
                olost_q <= '0;
                olast_q <= 1'b1;
                ret_q <= RET_IDLE;
                state_q <= S_EMIT;
              end else if (fwd == 16'd0 || fwd[15]) begin
                state_q <= S_IDLE;
              end else if (fwd == 16'd1) begin
                ld_q <= seq_i;
                okind_q <= KIND_DELIVER;
                oseq_q <= seq_i;
                ohdl_q <= handle_i;
                olost_q <= '0;
                olast_q <= 1'b0;
                pend_q <= 1'b1;
                state_q <= S_DSCAN;
              end else begin
                pend_q <= 1'b0;
                state_q <= S_ASCAN;
              end
            end else if (vld_q != '0 && wait_act_q) begin
              best_q <= 16'hFFFF;
              bseq_q <= ld_q + 16'd1;
              if ((wait_q < WaitMax ? wait_q + 9'd1 : wait_q) >= {1'b0, hold_q}) begin
                state_q <= S_TSCAN;
              end
              if (wait_q < WaitMax) begin
                wait_q <= wait_q + 9'd1;
              end
            end
          end
        end
        S_ASCAN: begin
          if (hit_now) begin
            hit_v_q <= 1'b1;
            hit_q <= idx_q;
          end
          if (!vld_q[idx_q] && !free_v_q) begin
            free_v_q <= 1'b1;
            free_q <= idx_q;
          end
          idx_q <= idx_q + IdxW'(1);
          if (scan_end) begin
            state_q <= S_ADEC;
          end
        end
        S_ADEC: begin
          idx_q <= '0;
          hit_v_q <= 1'b0;
          if (hit_v_q) begin
            state_q <= S_IDLE;
          end else if (free_v_q) begin
            vld_q[free_q] <= 1'b1;
            state_q <= S_DSCAN;
          end else begin
            okind_q <= KIND_DROP;
            oseq_q <= seq_q;
            ohdl_q <= hdl_q;
            olost_q <= '0;
            olast_q <= 1'b1;
            ret_q <= RET_IDLE;
            state_q <= S_EMIT;
          end
        end
        S_DSCAN: begin
          if (hit_now) begin
            hit_v_q <= 1'b1;
            hit_q <= idx_q;
          end
          idx_q <= idx_q + IdxW'(1);
          if (scan_end) begin
            state_q <= S_DDEC;
          end
        end
        S_DDEC: begin
          idx_q <= '0;
          hit_v_q <= 1'b0;
          if (hit_v_q) begin
            if (pend_q) begin
              // another delivery follows the waiting result
              olast_q <= 1'b0;
              ret_q <= RET_DRAIN;
              state_q <= S_EMIT;
            end else begin
              vld_q[hit_q] <= 1'b0;
              ld_q <= nxt;
              okind_q <= KIND_DELIVER;
              oseq_q <= nxt;
              ohdl_q <= ehdl_q[hit_q];
              olost_q <= '0;
              olast_q <= 1'b0;
              pend_q <= 1'b1;
              state_q <= S_DSCAN;
            end
          end else begin
            if (vld_q == '0) begin
              wait_act_q <= 1'b0;
              wait_q <= '0;
            end else if (!wait_act_q) begin
              wait_act_q <= 1'b1;
              wait_q <= '0;
            end
            olast_q <= 1'b1;
            ret_q <= RET_IDLE;
            state_q <= pend_q ? S_EMIT : S_IDLE;
          end
        end
        S_TSCAN: begin
          if (vld_q[idx_q] && d_cur < best_q) begin
            best_q <= d_cur;
            bseq_q <= eseq_q[idx_q];
          end
          idx_q <= idx_q + IdxW'(1);
          if (scan_end) begin
            state_q <= S_TDEC;
          end
        end
        S_TDEC: begin
          idx_q <= '0;
          reqi_q <= '0;
          if (wait_q < {hold_q, 1'b0}) begin
            ask_q <= (best_q < {10'd0, run_cap}) ? best_q[5:0] : run_cap;
            state_q <= (best_q == 16'd0 || run_cap == 6'd0) ? S_IDLE : S_REQ;
          end else begin
            okind_q <= KIND_LOST;
            oseq_q <= nxt;
            ohdl_q <= '0;
            olost_q <= best_q;
            olast_q <= 1'b0;
            ld_q <= bseq_q - 16'd1;
            wait_act_q <= 1'b0;
            wait_q <= '0;
            pend_q <= 1'b1;
            state_q <= S_DSCAN;
          end
        end
        S_REQ: begin
          okind_q <= KIND_RETX;
          oseq_q <= nxt + {10'd0, reqi_q};
          ohdl_q <= '0;
          olost_q <= '0;
          olast_q <= (reqi_q + 6'd1 == ask_q);
          reqi_q <= reqi_q + 6'd1;
          ret_q <= (reqi_q + 6'd1 == ask_q) ? RET_IDLE : RET_REQ;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_stall_i) begin
            unique case (ret_q)
              RET_DRAIN: begin
                vld_q[hit_q] <= 1'b0;
                ld_q <= nxt;
                okind_q <= KIND_DELIVER;
                oseq_q <= nxt;
                ohdl_q <= ehdl_q[hit_q];
                olost_q <= '0;
                olast_q <= 1'b0;
                state_q <= S_DSCAN;
              end
              RET_REQ:   state_q <= S_REQ;
              default:   state_q <= S_IDLE;
            endcase
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/srb_checker.sv
// Port-level checker for the reorder buffer, bound to the top level
`include "seq_reorder_buffer_core_defines.svh"
module srb_checker import srb_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [15:0] out_handle_o,
  input logic [15:0] lost_count_o
);
  `SRB_ASSERT_IMP(a_busy_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  `SRB_ASSERT_IMP(a_req_nohdl, clk_i, rst_ni, out_valid_o && kind_o == KIND_RETX, out_handle_o == 16'd0)
  `SRB_ASSERT_IMP(a_lost_only, clk_i, rst_ni, out_valid_o && kind_o != KIND_LOST, lost_count_o == 16'd0)
  `SRB_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(kind_o))
endmodule

bind seq_reorder_buffer_core srb_checker u_srb_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .kind_o(kind_o),
  .out_handle_o(out_handle_o), .lost_count_o(lost_count_o)
);

>>> tb/sv/seq_reorder_buffer_core_tb.sv
// Self-checking testbench for the sequence-number reorder buffer core
module seq_reorder_buffer_core_tb;
  import srb_pkg::*;

  localparam int unsigned Slots = 32;
  localparam int unsigned SettleCycles = 1400;
  localparam int unsigned CycleLimit = 3000000;

  typedef struct {
    kind_e       kind;
    logic [15:0] seq;
    logic [15:0] handle;
    logic [15:0] lost;
    logic        last;
  } result_t;

  typedef struct {
    cmd_e        cmd;
    logic [15:0] seq;
    logic [15:0] handle;
    bit          typed;
    int          n;
    kind_e       kind;
    logic [15:0] eseq;
    logic [15:0] ehandle;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        command_i;
  logic [15:0] seq_i;
  logic [15:0] handle_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [15:0] out_seq_o;
  logic [15:0] out_handle_o;
  logic [15:0] lost_count_o;
  logic        last_o;

  seq_reorder_buffer_core u_top (.*);

  result_t     pending_results[$];
  result_t     step_out[$];
  int          errors = 0;
  bit          quiet = 0;
  bit          hold_off = 0;
  int unsigned cycles = 0;

  // mirror of the block state
  int unsigned hold_ticks_m, max_run_m;
  bit          started_m, wait_on_m;
  logic [15:0] last_dlv_m;
  int unsigned wait_cnt_m;
  bit          slot_valid[Slots];
  logic [15:0] slot_seq[Slots];
  logic [15:0] slot_handle[Slots];

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void add_result(kind_e k, logic [15:0] s, logic [15:0] h,
                                     logic [15:0] lost);
    result_t r;
    r.kind = k; r.seq = s; r.handle = h; r.lost = lost; r.last = 0;
    step_out.insert(step_out.size(), r);
  endfunction

  function automatic int slot_of(logic [15:0] s);
    for (int i = 0; i < Slots; i++)
      if (slot_valid[i] && slot_seq[i] == s) return i;
    return -1;
  endfunction

  function automatic bit store_empty();
    foreach (slot_valid[i]) if (slot_valid[i]) return 0;
    return 1;
  endfunction

  function automatic void drain_runs();
    logic [15:0] nxt;
    int k;
    forever begin
      nxt = last_dlv_m + 16'd1;
      k = slot_of(nxt);
      if (k < 0) break;
      slot_valid[k] = 0;
      last_dlv_m = nxt;
      add_result(KIND_DELIVER, nxt, slot_handle[k], 16'd0);
    end
    if (store_empty()) begin
      wait_on_m = 0;
      wait_cnt_m = 0;
    end else if (!wait_on_m) begin
      wait_on_m = 1;
      wait_cnt_m = 0;
    end
  endfunction

  function automatic void packet_in(logic [15:0] s, logic [15:0] h);
    logic [15:0] fwd;
    int k;
    if (!started_m) begin
      started_m = 1;
      last_dlv_m = s;
      add_result(KIND_DELIVER, s, h, 16'd0);
      return;
    end
    fwd = s - last_dlv_m;
    if (fwd == 16'd0 || fwd >= 16'h8000) return;
    if (fwd == 16'd1) begin
      last_dlv_m = s;
      add_result(KIND_DELIVER, s, h, 16'd0);
      drain_runs();
      return;
    end
    k = slot_of(s);
    if (k >= 0) begin
      slot_handle[k] = h;
      return;
    end
    for (int i = 0; i < Slots; i++) begin
      if (!slot_valid[i]) begin
        slot_valid[i] = 1;
        slot_seq[i] = s;
        slot_handle[i] = h;
        drain_runs();
        return;
      end
    end
    add_result(KIND_DROP, s, h, 16'd0);
  endfunction

  function automatic void tick_in();
    logic [15:0] missing, upto, best, d;
    int unsigned run, ask;
    if (store_empty() || !wait_on_m) return;
    if (wait_cnt_m < 511) wait_cnt_m++;
    if (wait_cnt_m < hold_ticks_m) return;
    missing = last_dlv_m + 16'd1;
    upto = missing;
    best = 16'hFFFF;
    for (int k = 0; k < Slots; k++) begin
      if (!slot_valid[k]) continue;
      d = slot_seq[k] - missing;
      if (d < best) begin
        best = d;
        upto = slot_seq[k];
      end
    end
    if (wait_cnt_m < 2 * hold_ticks_m) begin
      run = max_run_m > 32 ? 32 : max_run_m;
      ask = best < run ? best : run;
      for (int unsigned i = 0; i < ask; i++)
        add_result(KIND_RETX, missing + i[15:0], 16'd0, 16'd0);
      return;
    end
    add_result(KIND_LOST, missing, 16'd0, best);
    last_dlv_m = upto - 16'd1;
    wait_on_m = 0;
    wait_cnt_m = 0;
    drain_runs();
  endfunction

  function automatic void reorder_step(cmd_e c, logic [15:0] s, logic [15:0] h);
    step_out.delete();
    if (c == CMD_ARRIVE) packet_in(s, h);
    else tick_in();
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1;
  endfunction

  task automatic send(cmd_e c, logic [15:0] s, logic [15:0] h);
    in_valid_i <= 1;
    command_i <= c;
    seq_i <= s;
    handle_i <= h;
    do @(posedge clk_i); while (in_stall_o);
    reorder_step(c, s, h);
    foreach (step_out[i]) pending_results.insert(pending_results.size(), step_out[i]);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid_i <= 0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [7:0] v);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
    if (idx == REG_HOLD) hold_ticks_m = v;
    else max_run_m = v & 8'h3F;
  endtask

  // receiver
  initial begin
    out_stall_i = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_stall_i <= 1;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      out_stall_i <= 0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // checker
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d seq %h", $time, kind_o, out_seq_o);
        errors++;
      end else begin
        e = pending_results[0];
        pending_results.delete(0);
        if (kind_o !== e.kind || out_seq_o !== e.seq || out_handle_o !== e.handle ||
            lost_count_o !== e.lost || last_o !== e.last) begin
          $display("%0t: mismatch exp k%0d s%h h%h l%h last%0b act k%0d s%h h%h l%h last%0b",
                   $time, e.kind, e.seq, e.handle, e.lost, e.last,
                   kind_o, out_seq_o, out_handle_o, lost_count_o, last_o);
          errors++;
        end
      end
    end
  end

  task automatic random_phase(int unsigned items);
    int unsigned done_items = 0;
    int unsigned r;
    logic [15:0] s, fwd;
    while (done_items < items) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        s = last_dlv_m + 16'd2;
        for (int i = 0; i < 36; i++) send(CMD_ARRIVE, s + i[15:0], 16'($urandom));
        done_items += 36;
      end else if (r < 25) begin
        send(CMD_TICK, 16'($urandom), 16'($urandom));
        done_items++;
      end else begin
        if (r < 35) s = 16'($urandom);
        else if (r < 50) s = last_dlv_m + 16'd1;
        else s = last_dlv_m + 16'($urandom_range(1, 14));
        fwd = s - last_dlv_m;
        send(CMD_ARRIVE, s, 16'($urandom));
        if (fwd != 0 && fwd < 16'h8000) done_items++;
      end
    end
  endtask

  row_t rows[] = '{
    '{CMD_ARRIVE, 16'hFFFE, 16'hFFFF, 1, 1, KIND_DELIVER, 16'hFFFE, 16'hFFFF},
    '{CMD_ARRIVE, 16'hFFFE, 16'h0001, 1, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_ARRIVE, 16'h7FFE, 16'h0002, 1, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_ARRIVE, 16'hFFFF, 16'h0000, 1, 1, KIND_DELIVER, 16'hFFFF, 16'h0000},
    '{CMD_ARRIVE, 16'h0002, 16'h1234, 1, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_ARRIVE, 16'h0002, 16'hAAAA, 1, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_TICK,   16'h0000, 16'h0000, 0, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_TICK,   16'h0000, 16'h0000, 0, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_TICK,   16'h0000, 16'h0000, 0, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_TICK,   16'h0000, 16'h0000, 0, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_TICK,   16'h0000, 16'h0000, 0, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_ARRIVE, 16'h0000, 16'h5555, 0, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_ARRIVE, 16'h0001, 16'h0F0F, 0, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_TICK,   16'hFFFF, 16'hFFFF, 1, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_ARRIVE, 16'h0005, 16'hF0F0, 0, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_ARRIVE, 16'h0009, 16'h00FF, 0, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_TICK,   16'h0000, 16'h0000, 0, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_TICK,   16'h0000, 16'h0000, 0, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_TICK,   16'h0000, 16'h0000, 0, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_TICK,   16'h0000, 16'h0000, 0, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_TICK,   16'h0000, 16'h0000, 0, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_TICK,   16'h0000, 16'h0000, 0, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_TICK,   16'h0000, 16'h0000, 0, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_TICK,   16'h0000, 16'h0000, 0, 0, KIND_DELIVER, 16'h0, 16'h0},
    '{CMD_TICK,   16'h0000, 16'h0000, 0, 0, KIND_DELIVER, 16'h0, 16'h0}
  };

  initial begin
    result_t e;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_index_i = REG_HOLD;
    cfg_wdata_i = 0;
    in_valid_i = 0;
    command_i = CMD_ARRIVE;
    seq_i = 0;
    handle_i = 0;
    hold_ticks_m = 5;
    max_run_m = 8;
    started_m = 0;
    last_dlv_m = 0;
    wait_on_m = 0;
    wait_cnt_m = 0;
    foreach (slot_valid[i]) slot_valid[i] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: rows with typed results override the mirror's output
    foreach (rows[i]) begin
      in_valid_i <= 1;
      command_i <= rows[i].cmd;
      seq_i <= rows[i].seq;
      handle_i <= rows[i].handle;
      do @(posedge clk_i); while (in_stall_o);
      reorder_step(rows[i].cmd, rows[i].seq, rows[i].handle);
      if (rows[i].typed) begin
        if (rows[i].n > 0) begin
          e.kind = rows[i].kind; e.seq = rows[i].eseq; e.handle = rows[i].ehandle;
          e.lost = 0; e.last = 1;
          pending_results.insert(pending_results.size(), e);
        end
      end else begin
        foreach (step_out[j]) pending_results.insert(pending_results.size(), step_out[j]);
      end
    end
    settle();

    write_reg(REG_HOLD, 8'd1);
    write_reg(REG_RUN, 8'd1);
    random_phase(30);
    settle();
    write_reg(REG_HOLD, 8'd255);
    write_reg(REG_RUN, 8'd32);
    hold_off = 1;
    random_phase(35);
    settle();
    write_reg(REG_HOLD, 8'd0);
    write_reg(REG_RUN, 8'd0);
    random_phase(25);
    settle();
    write_reg(REG_HOLD, 8'd3);
    write_reg(REG_RUN, 8'hFF);
    random_phase(35);
    settle();
    write_reg(REG_HOLD, 8'd2);
    write_reg(REG_RUN, 8'd5);
    random_phase(35);
    quiet = 1;
    random_phase(30);
    settle();

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

>>> sim.f
+incdir+hdl
hdl/srb_pkg.sv
hdl/seq_reorder_buffer_core.sv
hdl/srb_checker.sv
tb/sv/seq_reorder_buffer_core_tb.sv
